// File: hw/rtl/vrdw_pkg.sv
// shared types and constants for the voxel ray dda walker
package vrdw_pkg;

    localparam int DEF_FRAC_BITS     = 16;
    localparam int DEF_MATERIAL_BITS = 16;
    localparam int DIR_W             = 20;
    localparam int SUM_W             = 2 * DIR_W;
    localparam int MAT_W             = 16;
    localparam logic [31:0] INF32    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_QUERY  = 2'd0,
        KIND_HIT    = 2'd1,
        KIND_MISS   = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef enum logic {
        ARITH_DIV  = 1'b0,
        ARITH_SQRT = 1'b1
    } t_arith_op;

    typedef struct packed {
        logic      start;
        t_arith_op op;
    } t_arith_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_arith_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQSUM,
        ST_SQRT,
        ST_LIMIT,
        ST_CROSS,
        ST_SPACE,
        ST_REPLY
    } t_state;

endpackage

// File: hw/rtl/vrdw_arith.sv
// shared bit-serial divider and square root unit
module vrdw_arith #(
    parameter int FRAC_BITS = vrdw_pkg::DEF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vrdw_pkg::t_arith_req        i_req,
    input  logic [33+FRAC_BITS-1:0]     i_num,
    input  logic [vrdw_pkg::DIR_W-1:0]  i_den,
    output vrdw_pkg::t_arith_rsp        o_rsp,
    output logic [31:0]                 o_result
);

    localparam int NW = 33 + FRAC_BITS;
    localparam int RW = vrdw_pkg::DIR_W + 4;
    localparam int CW = $clog2(NW + 1);
    localparam int SW = vrdw_pkg::SUM_W;

    logic [NW-1:0]               r_a, n_a;
    logic [RW-1:0]               r_rem, n_rem;
    logic [vrdw_pkg::DIR_W-1:0]  r_den, n_den;
    logic [vrdw_pkg::DIR_W-1:0]  r_root, n_root;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    vrdw_pkg::t_arith_op         r_op, n_op;

    logic [RW-1:0] shifted;
    logic [RW-1:0] trial;
    logic [RW:0]   diff;
    logic          ge;

    always_comb begin
        if (r_op == vrdw_pkg::ARITH_DIV) begin
            shifted = {r_rem[RW-2:0], r_a[NW-1]};
            trial   = RW'(r_den);
        end else begin
            shifted = {r_rem[RW-3:0], r_a[NW-1:NW-2]};
            trial   = RW'({r_root, 2'b01});
        end
        diff = {1'b0, shifted} - {1'b0, trial};
        ge   = !diff[RW];
    end

    always_comb begin
        n_a    = r_a;
        n_rem  = r_rem;
        n_den  = r_den;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_op   = r_op;
        n_done = 1'b0;
        if (i_req.start) begin
            n_op   = i_req.op;
            n_rem  = '0;
            n_root = '0;
            n_den  = i_den;
            n_busy = 1'b1;
            if (i_req.op == vrdw_pkg::ARITH_DIV) begin
                n_a   = i_num;
                n_cnt = CW'(NW);
            end else begin
                n_a   = {i_num[SW-1:0], {(NW-SW){1'b0}}};
                n_cnt = CW'(vrdw_pkg::DIR_W);
            end
        end else if (r_busy) begin
            n_rem = ge ? diff[RW-1:0] : shifted;
            if (r_op == vrdw_pkg::ARITH_DIV) begin
                n_a = {r_a[NW-2:0], ge};
            end else begin
                n_a    = {r_a[NW-3:0], 2'b00};
                n_root = {r_root[vrdw_pkg::DIR_W-2:0], ge};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= vrdw_pkg::ARITH_DIV;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_a    <= n_a;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_root <= n_root;
    end

    always_comb begin
        o_rsp.busy = r_busy;
        o_rsp.done = r_done;
        if (r_op == vrdw_pkg::ARITH_DIV) begin
            o_result = (|r_a[NW-1:32]) ? vrdw_pkg::INF32 : r_a[31:0];
        end else begin
            o_result = 32'(r_root);
        end
    end

endmodule

// File: hw/rtl/voxel_ray_dda_walker_unit.sv
// voxel ray dda walker top level: setup sequencer and voxel stepping
// A start word (tuser 0) sets up a ray and, after setup, returns a query word for the
// voxel holding the origin, or instead a reject word if its direction is zero. While a
// walk is active, each reply word (tuser 1) with the queried material returns a hit,
// the next query or a miss; a reply word outside a walk is dropped. Setup runs on one
// shared bit-serial unit: the squared length, the square root, one division for the
// limit, then a crossing and a spacing division per axis with nonzero direction (a zero
// axis skips both). An accepted reply steps or computes the hit with one 32x20 multiply.
// The input is not ready while setup runs, a reply is computed or a result word waits.
module voxel_ray_dda_walker_unit #(
    parameter int FRAC_BITS     = vrdw_pkg::DEF_FRAC_BITS,
    parameter int MATERIAL_BITS = vrdw_pkg::DEF_MATERIAL_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data,   // air_code
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance, material, zero pad
    input  logic [207:0] i_s_tdata,
    input  logic         i_s_tuser,       // mode
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // voxel_x, voxel_y, voxel_z, normal_x, normal_y, normal_z, hit_distance,
    // hit_material, zero pad
    output logic [103:0] o_m_tdata,
    output logic [1:0]   o_m_tuser        // kind
);

    localparam int NW = 33 + FRAC_BITS;
    localparam int DW = vrdw_pkg::DIR_W;
    localparam int SW = vrdw_pkg::SUM_W;
    localparam logic [15:0] MAT_MASK = (MATERIAL_BITS >= 16) ? 16'hFFFF :
                                       16'((32'd1 << MATERIAL_BITS) - 32'd1);
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    vrdw_pkg::t_state r_state, n_state;

    logic [15:0]          r_air;
    logic [15:0]          r_cell [3], n_cell [3];
    logic [1:0]           r_sign [3], n_sign [3];
    logic [1:0]           r_norm [3], n_norm [3];
    logic [31:0]          r_nc [3],   n_nc [3];
    logic [31:0]          r_sp [3],   n_sp [3];
    logic [DW-1:0]        r_dir [3],  n_dir [3];
    logic [FRAC_BITS-1:0] r_frac [3], n_frac [3];
    logic [31:0]          r_maxd, n_maxd;
    logic [SW-1:0]        r_sum, n_sum;
    logic [DW-1:0]        r_len, n_len;
    logic [31:0]          r_param, n_param;
    logic [31:0]          r_limit, n_limit;
    logic [15:0]          r_mat, n_mat;
    logic [1:0]           r_ax, n_ax;
    logic                 r_walk, n_walk;
    logic                 r_issued, n_issued;
    logic                 r_ovalid, n_ovalid;
    vrdw_pkg::t_kind      r_okind, n_okind;
    logic [31:0]          r_odist, n_odist;
    logic [15:0]          r_omat, n_omat;

    vrdw_pkg::t_arith_req arith_req;
    vrdw_pkg::t_arith_rsp arith_rsp;
    logic [NW-1:0]        arith_num;
    logic [DW-1:0]        arith_den;
    logic [31:0]          arith_res;

    logic          s_acc;
    logic          dir_zero;
    logic [DW-1:0] cur_dir;
    logic [DW-1:0] cur_abs;
    logic          cur_zero;
    logic [2*DW-1:0] sq;
    logic [FRAC_BITS:0] cross_num;
    logic [1:0]    step_ax;
    logic [31:0]   new_param;
    logic [32:0]   nc_sum;
    logic [31:0]   nc_sat;
    logic [51:0]   prod;
    logic [51:0]   prod_sh;
    logic          is_hit;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == vrdw_pkg::ST_IDLE) && !r_ovalid;
    assign dir_zero   = (i_s_tdata[115:96] == '0) && (i_s_tdata[135:116] == '0) &&
                        (i_s_tdata[155:136] == '0);

    assign cur_dir  = r_dir[r_ax];
    assign cur_abs  = cur_dir[DW-1] ? DW'(-cur_dir) : cur_dir;
    assign cur_zero = (cur_dir == '0);
    assign sq       = (2*DW)'($signed(cur_dir)) * (2*DW)'($signed(cur_dir));
    assign cross_num = cur_dir[DW-1] ? (FRAC_BITS+1)'(r_frac[r_ax]) :
                                      ONE - (FRAC_BITS+1)'(r_frac[r_ax]);

    always_comb begin
        if (r_nc[0] <= r_nc[1] && r_nc[0] <= r_nc[2]) begin
            step_ax = 2'd0;
        end else if (r_nc[1] <= r_nc[2]) begin
            step_ax = 2'd1;
        end else begin
            step_ax = 2'd2;
        end
    end

    assign new_param = r_nc[step_ax];
    assign nc_sum    = {1'b0, r_nc[step_ax]} + {1'b0, r_sp[step_ax]};
    assign nc_sat    = (r_nc[step_ax] == vrdw_pkg::INF32 || r_sp[step_ax] == vrdw_pkg::INF32 ||
                        nc_sum[32]) ? vrdw_pkg::INF32 : nc_sum[31:0];
    assign prod      = 52'(r_param) * 52'(r_len);
    assign prod_sh   = prod >> FRAC_BITS;
    assign is_hit    = (r_mat & MAT_MASK) != (r_air & MAT_MASK);

    always_comb begin
        arith_req.start = 1'b0;
        arith_req.op    = vrdw_pkg::ARITH_DIV;
        arith_num       = NW'({r_maxd, {FRAC_BITS{1'b0}}});
        arith_den       = r_len;
        unique case (r_state)
            vrdw_pkg::ST_SQRT: begin
                arith_req.start = !r_issued;
                arith_req.op    = vrdw_pkg::ARITH_SQRT;
                arith_num       = NW'(r_sum);
            end
            vrdw_pkg::ST_LIMIT: begin
                arith_req.start = !r_issued;
            end
            vrdw_pkg::ST_CROSS: begin
                arith_req.start = !r_issued && !cur_zero;
                arith_num       = NW'({cross_num, {FRAC_BITS{1'b0}}});
                arith_den       = cur_abs;
            end
            vrdw_pkg::ST_SPACE: begin
                arith_req.start = !r_issued;
                arith_num       = NW'(1) << (2 * FRAC_BITS);
                arith_den       = cur_abs;
            end
            default: begin
                arith_req.start = 1'b0;
            end
        endcase
    end

    vrdw_arith #(
        .FRAC_BITS (FRAC_BITS)
    ) u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (arith_req),
        .i_num    (arith_num),
        .i_den    (arith_den),
        .o_rsp    (arith_rsp),
        .o_result (arith_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vrdw_pkg::ST_IDLE: begin
                if (s_acc && !i_s_tuser && !dir_zero) begin
                    n_state = vrdw_pkg::ST_SQSUM;
                end else if (s_acc && i_s_tuser && r_walk) begin
                    n_state = vrdw_pkg::ST_REPLY;
                end
            end
            vrdw_pkg::ST_SQSUM: begin
                if (r_ax == 2'd2) n_state = vrdw_pkg::ST_SQRT;
            end
            vrdw_pkg::ST_SQRT: begin
                if (arith_rsp.done) n_state = vrdw_pkg::ST_LIMIT;
            end
            vrdw_pkg::ST_LIMIT: begin
                if (arith_rsp.done) n_state = vrdw_pkg::ST_CROSS;
            end
            vrdw_pkg::ST_CROSS: begin
                if (cur_zero) begin
                    n_state = (r_ax == 2'd2) ? vrdw_pkg::ST_IDLE : vrdw_pkg::ST_CROSS;
                end else if (arith_rsp.done) begin
                    n_state = vrdw_pkg::ST_SPACE;
                end
            end
            vrdw_pkg::ST_SPACE: begin
                if (arith_rsp.done) begin
                    n_state = (r_ax == 2'd2) ? vrdw_pkg::ST_IDLE : vrdw_pkg::ST_CROSS;
                end
            end
            vrdw_pkg::ST_REPLY: begin
                n_state = vrdw_pkg::ST_IDLE;
            end
            default: begin
                n_state = vrdw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cell   = r_cell;
        n_sign   = r_sign;
        n_norm   = r_norm;
        n_nc     = r_nc;
        n_sp     = r_sp;
        n_dir    = r_dir;
        n_frac   = r_frac;
        n_maxd   = r_maxd;
        n_sum    = r_sum;
        n_len    = r_len;
        n_param  = r_param;
        n_limit  = r_limit;
        n_mat    = r_mat;
        n_ax     = r_ax;
        n_walk   = r_walk;
        n_issued = r_issued;
        n_okind  = r_okind;
        n_odist  = r_odist;
        n_omat   = r_omat;
        n_ovalid = r_ovalid && !i_m_tready;
        if (arith_req.start) n_issued = 1'b1;
        if (arith_rsp.done)  n_issued = 1'b0;
        unique case (r_state)
            vrdw_pkg::ST_IDLE: begin
                if (s_acc && !i_s_tuser) begin
                    n_walk  = 1'b0;
                    n_maxd  = i_s_tdata[187:156];
                    n_sum   = '0;
                    n_ax    = 2'd0;
                    n_param = '0;
                    for (int k = 0; k < 3; k++) begin
                        n_cell[k] = 16'($signed(i_s_tdata[32*k +: 32]) >>> FRAC_BITS);
                        n_frac[k] = i_s_tdata[32*k +: FRAC_BITS];
                        n_dir[k]  = i_s_tdata[96 + DW*k +: DW];
                        n_norm[k] = 2'b00;
                    end
                    if (dir_zero) begin
                        n_ovalid = 1'b1;
                        n_okind  = vrdw_pkg::KIND_REJECT;
                        n_odist  = '0;
                        n_omat   = '0;
                    end
                end else if (s_acc && i_s_tuser) begin
                    n_mat = i_s_tdata[203:188];
                end
            end
            vrdw_pkg::ST_SQSUM: begin
                n_sum = r_sum + SW'(sq);
                n_ax  = (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
            end
            vrdw_pkg::ST_SQRT: begin
                if (arith_rsp.done) n_len = arith_res[DW-1:0];
            end
            vrdw_pkg::ST_LIMIT: begin
                if (arith_rsp.done) n_limit = arith_res;
            end
            vrdw_pkg::ST_CROSS: begin
                if (cur_zero) begin
                    n_sign[r_ax] = 2'b00;
                    n_nc[r_ax]   = vrdw_pkg::INF32;
                    n_sp[r_ax]   = vrdw_pkg::INF32;
                end else begin
                    n_sign[r_ax] = cur_dir[DW-1] ? 2'b11 : 2'b01;
                    if (arith_rsp.done) n_nc[r_ax] = arith_res;
                end
            end
            vrdw_pkg::ST_SPACE: begin
                if (arith_rsp.done) n_sp[r_ax] = arith_res;
            end
            vrdw_pkg::ST_REPLY: begin
                if (is_hit) begin
                    n_walk   = 1'b0;
                    n_ovalid = 1'b1;
                    n_okind  = vrdw_pkg::KIND_HIT;
                    n_odist  = (|prod_sh[51:32]) ? vrdw_pkg::INF32 : prod_sh[31:0];
                    n_omat   = r_mat;
                end else begin
                    n_cell[step_ax] = r_cell[step_ax] + {{14{r_sign[step_ax][1]}},
                                                         r_sign[step_ax]};
                    n_param     = new_param;
                    n_nc[step_ax] = nc_sat;
                    for (int k = 0; k < 3; k++) n_norm[k] = 2'b00;
                    n_norm[step_ax] = 2'(-r_sign[step_ax]);
                    n_ovalid = 1'b1;
                    n_odist  = '0;
                    n_omat   = '0;
                    if (new_param == vrdw_pkg::INF32 || new_param > r_limit) begin
                        n_walk  = 1'b0;
                        n_okind = vrdw_pkg::KIND_MISS;
                    end else begin
                        n_okind = vrdw_pkg::KIND_QUERY;
                    end
                end
            end
            default: begin
                n_walk = r_walk;
            end
        endcase
        if ((r_state == vrdw_pkg::ST_CROSS && cur_zero) ||
            (r_state == vrdw_pkg::ST_SPACE && arith_rsp.done)) begin
            if (r_ax == 2'd2) begin
                n_ax     = 2'd0;
                n_walk   = 1'b1;
                n_ovalid = 1'b1;
                n_okind  = vrdw_pkg::KIND_QUERY;
                n_odist  = '0;
                n_omat   = '0;
            end else begin
                n_ax = r_ax + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vrdw_pkg::ST_IDLE;
            r_air    <= '0;
            r_walk   <= 1'b0;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
            r_ax     <= 2'd0;
            r_param  <= '0;
            r_limit  <= '0;
            r_len    <= '0;
            for (int k = 0; k < 3; k++) begin
                r_cell[k] <= '0;
                r_sign[k] <= '0;
                r_norm[k] <= '0;
                r_nc[k]   <= '0;
                r_sp[k]   <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_walk   <= n_walk;
            r_issued <= n_issued;
            r_ovalid <= n_ovalid;
            r_ax     <= n_ax;
            r_param  <= n_param;
            r_limit  <= n_limit;
            r_len    <= n_len;
            r_cell   <= n_cell;
            r_sign   <= n_sign;
            r_norm   <= n_norm;
            r_nc     <= n_nc;
            r_sp     <= n_sp;
            if (i_cfg_wr_en) r_air <= i_cfg_wr_data;
        end
        r_dir   <= n_dir;
        r_frac  <= n_frac;
        r_maxd  <= n_maxd;
        r_sum   <= n_sum;
        r_mat   <= n_mat;
        r_okind <= n_okind;
        r_odist <= n_odist;
        r_omat  <= n_omat;
    end

    logic show_pos;
    assign show_pos = (r_okind == vrdw_pkg::KIND_QUERY) || (r_okind == vrdw_pkg::KIND_HIT);

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_okind;
    assign o_m_tdata  = {2'b00, r_omat, r_odist,
                         show_pos ? r_norm[2] : 2'b00,
                         show_pos ? r_norm[1] : 2'b00,
                         show_pos ? r_norm[0] : 2'b00,
                         show_pos ? r_cell[2] : 16'h0000,
                         show_pos ? r_cell[1] : 16'h0000,
                         show_pos ? r_cell[0] : 16'h0000};

endmodule

// File: hw/rtl/vrdw_checker.sv
// port-level checks for the voxel ray dda walker, bound to the top level
module vrdw_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [103:0] o_m_tdata,
    input logic [1:0]   o_m_tuser
);

    // one word in flight: no input taken while a result waits
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while result word pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result word changed");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == vrdw_pkg::KIND_REJECT |-> o_m_tdata == '0)
        else $error("rejected ray word carries data");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == vrdw_pkg::KIND_MISS |-> o_m_tdata == '0)
        else $error("miss word carries data");

    a_query_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == vrdw_pkg::KIND_QUERY |-> o_m_tdata[103:54] == '0)
        else $error("query word carries hit fields");

endmodule

bind voxel_ray_dda_walker_unit vrdw_checker u_vrdw_checker (.*);

// File: tb/tb_voxel_ray_dda_walker_unit.sv
// testbench for the voxel ray dda walker: random and directed rays checked against a predictor
`timescale 1ns / 1ps

module tb_voxel_ray_dda_walker_unit;

    localparam int FB = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic        mode;
        logic [31:0] ox, oy, oz;
        logic [19:0] dx, dy, dz;
        logic [31:0] max_dist;
        logic [15:0] material;
    } t_ray_word;

    typedef struct packed {
        vrdw_pkg::t_kind kind;
        logic [15:0] vx, vy, vz;
        logic [1:0]  nx, ny, nz;
        logic [31:0] hit_dist;
        logic [15:0] mat;
    } t_walk_word;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_wr_en = 0;
    logic [15:0]  i_cfg_wr_data = 0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [207:0] i_s_tdata = '0;
    logic         i_s_tuser = 0;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [103:0] o_m_tdata;
    logic [1:0]   o_m_tuser;

    voxel_ray_dda_walker_unit dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // predictor state
    logic [15:0] air;
    logic [15:0] vox[3];
    int          sgn[3];
    logic [31:0] cross_t[3], space_t[3];
    logic [31:0] tparam, tlimit, rlen;
    int          enorm[3];
    bit          active;

    t_ray_word  pending_q[$];
    t_walk_word walk_exp_q[$];
    int errors = 0, n_hit = 0, n_miss = 0, n_query = 0, n_rej = 0, n_in = 0;
    int send_idle = 22, recv_idle = 64;
    bit hold_send = 0;
    int quiet = 0;

    function automatic logic [31:0] sat32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [31:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic t_walk_word walk_word(vrdw_pkg::t_kind k, bit with_pos);
        t_walk_word w;
        w = '0;
        w.kind = k;
        if (with_pos) begin
            w.vx = vox[0]; w.vy = vox[1]; w.vz = vox[2];
            w.nx = 2'(enorm[0]); w.ny = 2'(enorm[1]); w.nz = 2'(enorm[2]);
        end
        return w;
    endfunction

    task automatic predict_walk(t_ray_word r);
        longint d[3];
        logic [63:0] sum, frac, ad, num, one, dist_v;
        logic [31:0] o[3];
        t_walk_word w;
        int ax;
        one = 64'd1 << FB;
        if (!r.mode) begin
            active = 0;
            d[0] = longint'($signed(r.dx));
            d[1] = longint'($signed(r.dy));
            d[2] = longint'($signed(r.dz));
            o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
            sum = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
            if (sum == 0) begin
                walk_exp_q.push_back(walk_word(vrdw_pkg::KIND_REJECT, 0));
                return;
            end
            rlen = int_sqrt(sum);
            tlimit = sat32((64'(r.max_dist) << FB) / rlen);
            for (int k = 0; k < 3; k++) begin
                frac = 64'(o[k][FB-1:0]);
                ad = 64'(d[k] < 0 ? -d[k] : d[k]);
                vox[k] = 16'($signed(o[k]) >>> FB);
                enorm[k] = 0;
                if (d[k] == 0) begin
                    sgn[k] = 0;
                    cross_t[k] = vrdw_pkg::INF32;
                    space_t[k] = vrdw_pkg::INF32;
                end else begin
                    num = d[k] > 0 ? one - frac : frac;
                    sgn[k] = d[k] > 0 ? 1 : -1;
                    cross_t[k] = sat32((num << FB) / ad);
                    space_t[k] = sat32((64'd1 << (2*FB)) / ad);
                end
            end
            tparam = 0;
            active = 1;
            walk_exp_q.push_back(walk_word(vrdw_pkg::KIND_QUERY, 1));
            return;
        end
        if (!active) return;
        if (r.material != air) begin
            dist_v = (64'(tparam) * 64'(rlen)) >> FB;
            w = walk_word(vrdw_pkg::KIND_HIT, 1);
            w.hit_dist = sat32(dist_v);
            w.mat = r.material;
            walk_exp_q.push_back(w);
            active = 0;
            return;
        end
        if (cross_t[0] <= cross_t[1] && cross_t[0] <= cross_t[2]) ax = 0;
        else if (cross_t[1] <= cross_t[2]) ax = 1;
        else ax = 2;
        vox[ax] = vox[ax] + 16'(sgn[ax]);
        tparam = cross_t[ax];
        cross_t[ax] = (cross_t[ax] == vrdw_pkg::INF32 || space_t[ax] == vrdw_pkg::INF32) ?
                      vrdw_pkg::INF32 : sat32(64'(cross_t[ax]) + 64'(space_t[ax]));
        for (int k = 0; k < 3; k++) enorm[k] = 0;
        enorm[ax] = -sgn[ax];
        if (tparam == vrdw_pkg::INF32 || tparam > tlimit) begin
            active = 0;
            walk_exp_q.push_back(walk_word(vrdw_pkg::KIND_MISS, 0));
        end else begin
            walk_exp_q.push_back(walk_word(vrdw_pkg::KIND_QUERY, 1));
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_ray_word w;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                predict_walk(pending_q.pop_front());
                n_in++;
            end
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (pending_q.size() != 0 && !hold_send &&
                    $urandom_range(99) >= send_idle) begin
                    w = pending_q[0];
                    i_s_tvalid <= 1;
                    i_s_tuser <= w.mode;
                    i_s_tdata <= {4'b0000, w.material, w.max_dist, w.dz, w.dy, w.dx,
                                  w.oz, w.oy, w.ox};
                end else begin
                    i_s_tvalid <= 0;
                end
            end
            i_m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_walk_word got, want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.kind = vrdw_pkg::t_kind'(o_m_tuser);
                got.vx = o_m_tdata[15:0];   got.vy = o_m_tdata[31:16];
                got.vz = o_m_tdata[47:32];  got.nx = o_m_tdata[49:48];
                got.ny = o_m_tdata[51:50];  got.nz = o_m_tdata[53:52];
                got.hit_dist = o_m_tdata[85:54]; got.mat = o_m_tdata[101:86];
                if (walk_exp_q.size() == 0) begin
                    report_mismatch("unexpected word", 64'(o_m_tuser), 64'd0);
                end else begin
                    want = walk_exp_q.pop_front();
                    unique case (want.kind)
                        vrdw_pkg::KIND_QUERY: n_query++;
                        vrdw_pkg::KIND_HIT:   n_hit++;
                        vrdw_pkg::KIND_MISS:  n_miss++;
                        default:              n_rej++;
                    endcase
                    if (got.kind != want.kind)
                        report_mismatch("kind", 64'(got.kind), 64'(want.kind));
                    if (got.vx != want.vx) report_mismatch("voxel_x", 64'(got.vx), 64'(want.vx));
                    if (got.vy != want.vy) report_mismatch("voxel_y", 64'(got.vy), 64'(want.vy));
                    if (got.vz != want.vz) report_mismatch("voxel_z", 64'(got.vz), 64'(want.vz));
                    if (got.nx != want.nx) report_mismatch("normal_x", 64'(got.nx), 64'(want.nx));
                    if (got.ny != want.ny) report_mismatch("normal_y", 64'(got.ny), 64'(want.ny));
                    if (got.nz != want.nz) report_mismatch("normal_z", 64'(got.nz), 64'(want.nz));
                    if (got.hit_dist != want.hit_dist)
                        report_mismatch("distance", 64'(got.hit_dist), 64'(want.hit_dist));
                    if (got.mat != want.mat)
                        report_mismatch("material", 64'(got.mat), 64'(want.mat));
                end
            end
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)) quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic t_ray_word start_word(logic [31:0] ox, oy, oz,
                                             logic [19:0] dx, dy, dz, logic [31:0] md);
        t_ray_word w;
        w = '0;
        w.ox = ox; w.oy = oy; w.oz = oz;
        w.dx = dx; w.dy = dy; w.dz = dz;
        w.max_dist = md;
        return w;
    endfunction

    function automatic t_ray_word reply_word(logic [15:0] m);
        t_ray_word w;
        w = '0;
        w.ox = $urandom; w.oy = $urandom; w.oz = $urandom;
        w.dx = 20'($urandom); w.dy = 20'($urandom); w.dz = 20'($urandom);
        w.max_dist = $urandom;
        w.mode = 1;
        w.material = m;
        return w;
    endfunction

    function automatic logic [19:0] rand_dir();
        case ($urandom_range(5))
            0: return 20'd0;
            1: return 20'h80000;
            2: return 20'h7FFFF;
            3: return 20'($signed($urandom_range(8192)) - 4096);
            default: return 20'($signed($urandom_range(262144)) - 131072);
        endcase
    endfunction

    function automatic logic [31:0] rand_origin();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            default: return 32'($signed($urandom_range(2097152)) - 1048576);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_q.size() != 0 || walk_exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_air(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= v;
        air = v;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
    endtask

    task automatic queue_walk(int steps);
        logic [15:0] m;
        pending_q.push_back(start_word(rand_origin(), rand_origin(), rand_origin(),
                                       rand_dir(), rand_dir(), rand_dir(),
                                       ($urandom_range(9) == 0) ? $urandom
                                                               : $urandom_range(2000000)));
        for (int s = 0; s < steps; s++) begin
            m = ($urandom_range(15) == 0) ? 16'($urandom) : air;
            pending_q.push_back(reply_word(m));
        end
    endtask

    initial begin
        air = 0;
        active = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: reply while idle, zero direction, axis rays, extremes, ties
        pending_q.push_back(reply_word(16'h1234));
        pending_q.push_back(start_word(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        pending_q.push_back(start_word(32'h0001_8000, 0, 0, 20'h10000, 0, 0, 32'h0004_0000));
        repeat (6) pending_q.push_back(reply_word(0));
        pending_q.push_back(start_word(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
                                       20'h80000, 20'h7FFFF, 20'h00001, 32'hFFFF_FFFF));
        pending_q.push_back(reply_word(0));
        pending_q.push_back(reply_word(0));
        pending_q.push_back(reply_word(16'hFFFF));
        pending_q.push_back(start_word(0, 0, 0, 20'h10000, 20'h10000, 20'h10000, 0));
        pending_q.push_back(reply_word(0));
        pending_q.push_back(start_word(32'h1234_5678, 0, 0, 0, 20'hF0000, 0, 32'h0010_0000));
        pending_q.push_back(reply_word(0));
        pending_q.push_back(start_word(0, 0, 0, 0, 0, 20'h00001, 32'hFFFF_FFFF));
        pending_q.push_back(reply_word(16'h0001));
        wait_drained();

        write_air(16'hFFFF);
        for (int i = 0; i < 40; i++) queue_walk($urandom_range(1, 12));
        wait_drained();
        write_air(16'h0005);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 22 : (phase == 1) ? 64 : 0;
            recv_idle = (phase == 0) ? 64 : (phase == 1) ? 22 : 0;
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(9) == 0) pending_q.push_back(reply_word(16'($urandom)));
                queue_walk($urandom_range(1, 12));
                if (i == 25) begin
                    hold_send = 1;
                    while (walk_exp_q.size() != 0 || (i_s_tvalid && !o_s_tready))
                        @(posedge i_clk);
                    hold_send = 0;
                end
                while (pending_q.size() > 20) @(posedge i_clk);
            end
            wait_drained();
            write_air(16'($urandom));
        end
        write_air(16'h0000);
        for (int i = 0; i < 30; i++) queue_walk($urandom_range(1, 12));
        wait_drained();

        $display("%0d words in: %0d queries, %0d hits, %0d misses, %0d rejects",
                 n_in, n_query, n_hit, n_miss, n_rej);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/vrdw_pkg.sv
hw/rtl/vrdw_arith.sv
hw/rtl/voxel_ray_dda_walker_unit.sv
hw/rtl/vrdw_checker.sv
tb/tb_voxel_ray_dda_walker_unit.sv
